@@ sv/l3d_pkg.sv @@
// shared constants and types for the 3d lut trilinear sampler
// no dependencies; imported by the interfaces, the map unit and the top level
package l3d_pkg;

   localparam int MAX_LATTICE = 32;
   localparam int STORE_DEPTH = MAX_LATTICE * MAX_LATTICE * MAX_LATTICE;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int VAL_W       = 16;
   localparam int FRAC_W      = 16;
   localparam int POS_W       = FRAC_W + 1;
   localparam int SIZE_W      = 6;
   localparam int ROW_W       = 2 * SIZE_W;
   localparam int CORNER_W    = 3 * SIZE_W;
   localparam int WORD_W      = 3 * VAL_W;
   localparam int ENTRY_W     = 15;
   localparam int CH_W        = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int LANES       = 3;

   localparam logic [POS_W-1:0] ONE_Q16 = POS_W'(1) << FRAC_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LATTICE_SIZE = 3'd0,
      CSR_TABLE_VALID  = 3'd1,
      CSR_MIN_RED      = 3'd2,
      CSR_MIN_GREEN    = 3'd3,
      CSR_MIN_BLUE     = 3'd4,
      CSR_MAX_RED      = 3'd5,
      CSR_MAX_GREEN    = 3'd6,
      CSR_MAX_BLUE     = 3'd7
   } csr_idx_type;

   typedef enum logic [CH_W-1:0] {
      CH_RED   = 2'd0,
      CH_GREEN = 2'd1,
      CH_BLUE  = 2'd2,
      CH_NONE  = 2'd3
   } ch_type;

   typedef logic [LANES-1:0][VAL_W-1:0] val_vec_type;
   typedef logic [LANES-1:0][POS_W-1:0] pos_vec_type;

   typedef struct packed {
      logic busy;
      logic done;
   } map_status_type;

endpackage

@@ sv/l3d_if.sv @@
// handshake channels of the 3d lut trilinear sampler
// depends on l3d_pkg
interface l3d_req_if;
   import l3d_pkg::*;
   logic                valid;
   logic                ready;
   logic                cmd;
   logic [ENTRY_W-1:0]  entry_index;
   logic [VAL_W-1:0]    red_value;
   logic [VAL_W-1:0]    green_value;
   logic [VAL_W-1:0]    blue_value;
   logic [CH_W-1:0]     out_channel;
   modport source (output valid, cmd, entry_index, red_value, green_value, blue_value,
                   out_channel, input ready);
   modport sink (input valid, cmd, entry_index, red_value, green_value, blue_value,
                 out_channel, output ready);
endinterface

interface l3d_rsp_if;
   import l3d_pkg::*;
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] sampled_value;
   modport source (output valid, sampled_value, input ready);
   modport sink (input valid, sampled_value, output ready);
endinterface

interface l3d_csr_if;
   import l3d_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  addr;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink (input valid, addr, wdata, output ready);
endinterface

@@ sv/l3d_ram.sv @@
// generic simple dual port ram, one write and one registered read port
// no dependencies
module l3d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/l3d_map_unit.sv @@
// domain mapping of three color components, (v-min)/(max-min) in q.16, clamped
// to 0..1 (v itself if max <= min); restoring divider, one quotient bit per cycle per lane; depends on l3d_pkg
module l3d_map_unit import l3d_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  val_vec_type    v,
   input  val_vec_type    lo,
   input  val_vec_type    hi,
   output map_status_type status,
   output pos_vec_type    t
);

   typedef enum logic [1:0] {
      MODE_HOLD,
      MODE_SAT,
      MODE_DIV
   } mode_type;

   localparam int CNT_W = $clog2(FRAC_W);

   logic                          busy_ff;
   logic                          done_ff;
   logic [CNT_W-1:0]              cnt_ff;
   mode_type [LANES-1:0]          mode_ff;
   logic [LANES-1:0][VAL_W-1:0]   rem_ff;
   logic [LANES-1:0][VAL_W-1:0]   den_ff;
   logic [LANES-1:0][FRAC_W-1:0]  q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(FRAC_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [VAL_W:0] rem2;
      logic           ge;
      for (int k = 0; k < LANES; k++) begin
         if (start) begin
            rem_ff[k] <= v[k] - lo[k];
            den_ff[k] <= hi[k] - lo[k];
            if (hi[k] <= lo[k]) begin
               mode_ff[k] <= MODE_HOLD;
               q_ff[k]    <= v[k];
            end else if (v[k] <= lo[k]) begin
               mode_ff[k] <= MODE_HOLD;
               q_ff[k]    <= '0;
            end else if ((v[k] - lo[k]) >= (hi[k] - lo[k])) begin
               mode_ff[k] <= MODE_SAT;
               q_ff[k]    <= '0;
            end else begin
               mode_ff[k] <= MODE_DIV;
               q_ff[k]    <= '0;
            end
         end else if (busy_ff && mode_ff[k] == MODE_DIV) begin
            rem2 = {rem_ff[k], 1'b0};
            ge   = rem2 >= {1'b0, den_ff[k]};
            rem_ff[k] <= ge ? VAL_W'(rem2 - {1'b0, den_ff[k]}) : rem2[VAL_W-1:0];
            q_ff[k]   <= {q_ff[k][FRAC_W-2:0], ge};
         end
      end
   end

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         t[k] = (mode_ff[k] == MODE_SAT) ? ONE_Q16 : {1'b0, q_ff[k]};
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ sv/lut3d_trilinear_sampler.sv @@
// 3d color lut with trilinear sampling, top level
// depends on l3d_pkg, l3d_if, l3d_ram, l3d_map_unit
//
//  channel   dir  transaction
//  req_chan  in   cmd 0 writes one lattice point, cmd 1 samples a color
//  rsp_chan  out  one sampled_value per sample, none per write
//  csr_chan  in   register write, always ready
//
// a write is taken in idle; a sample runs through the per-axis restoring divider,
// scaling, addressing, eight corner reads on the one ram read port, blending and
// output, and no new req_chan transaction is accepted until it returns to idle
// a sample on an invalid table, a lattice size below two or channel three goes
// straight to output and returns zero
// reset clears control and the csr registers (the maxima to all ones); the lattice ram is not cleared
// a result waits in the output register while the next transaction is taken
module lut3d_trilinear_sampler import l3d_pkg::*; (
   input logic         clock,
   input logic         reset,
   l3d_req_if.sink     req_chan,
   l3d_rsp_if.source   rsp_chan,
   l3d_csr_if.sink     csr_chan
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP,
      ST_SCALE,
      ST_ROW,
      ST_BASE,
      ST_READ,
      ST_BLY0,
      ST_BLY1,
      ST_OUT
   } state_type;

   state_type                      state_ff;
   logic [SIZE_W-1:0]              size_ff;
   logic                           tvalid_ff;
   val_vec_type                    dmin_ff;
   val_vec_type                    dmax_ff;
   ch_type                         ch_ff;
   logic                           zero_ff;
   logic [LANES-1:0][SIZE_W-1:0]   i0_ff;
   logic [LANES-1:0][SIZE_W-1:0]   i1_ff;
   logic [LANES-1:0][FRAC_W-1:0]   fr_ff;
   logic [3:0][ROW_W-1:0]          row_ff;
   logic [3:0][CORNER_W-1:0]       base_ff;
   logic [3:0]                     k_ff;
   logic                           rd_oor_ff;
   logic [VAL_W-1:0]               first_ff;
   logic [3:0][VAL_W-1:0]          cx_ff;
   logic [VAL_W-1:0]               y0_ff;
   logic [VAL_W-1:0]               y1_ff;
   logic                           rsp_valid_ff;
   logic [VAL_W-1:0]               rsp_data_ff;

   logic                  req_acc;
   logic                  ram_we;
   logic [CORNER_W-1:0]   entry_w;
   logic [ADDR_W-1:0]     ram_raddr;
   logic [WORD_W-1:0]     ram_rdata;
   logic [CORNER_W-1:0]   corner;
   logic                  corner_oor;
   logic [VAL_W-1:0]      cur_val;
   logic [2:0]            pk;
   logic                  map_start;
   map_status_type        map_status;
   pos_vec_type           map_t;
   logic [SIZE_W-1:0]     n_lat;
   logic [VAL_W-1:0]      bl_a;
   logic [VAL_W-1:0]      bl_b;
   logic [FRAC_W-1:0]     bl_f;
   logic [VAL_W-1:0]      bl_res;
   logic                  zero_in;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign entry_w        = CORNER_W'(req_chan.entry_index);
   assign ram_we         = req_acc && !req_chan.cmd && (32'(entry_w) < STORE_DEPTH);
   assign zero_in        = !tvalid_ff || (size_ff < SIZE_W'(2)) ||
                           (req_chan.out_channel == CH_NONE);
   assign map_start      = req_acc && req_chan.cmd && !zero_in;
   assign n_lat          = size_ff - 1'b1;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= '0;
         tvalid_ff <= 1'b0;
         dmin_ff   <= '0;
         dmax_ff   <= '1;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_idx_type'(csr_chan.addr))
            CSR_LATTICE_SIZE: size_ff    <= csr_chan.wdata[SIZE_W-1:0];
            CSR_TABLE_VALID:  tvalid_ff  <= csr_chan.wdata[0];
            CSR_MIN_RED:      dmin_ff[0] <= csr_chan.wdata;
            CSR_MIN_GREEN:    dmin_ff[1] <= csr_chan.wdata;
            CSR_MIN_BLUE:     dmin_ff[2] <= csr_chan.wdata;
            CSR_MAX_RED:      dmax_ff[0] <= csr_chan.wdata;
            CSR_MAX_GREEN:    dmax_ff[1] <= csr_chan.wdata;
            CSR_MAX_BLUE:     dmax_ff[2] <= csr_chan.wdata;
            default: ;
         endcase
      end
   end

   l3d_map_unit u_map (
      .clock  (clock),
      .reset  (reset),
      .start  (map_start),
      .v      ({req_chan.blue_value, req_chan.green_value, req_chan.red_value}),
      .lo     (dmin_ff),
      .hi     (dmax_ff),
      .status (map_status),
      .t      (map_t)
   );

   l3d_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (entry_w[ADDR_W-1:0]),
      .wdata ({req_chan.blue_value, req_chan.green_value, req_chan.red_value}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // corner k: bit 0 red high, bit 1 blue high, bit 2 green high
   assign corner     = base_ff[k_ff[2:1]] +
                       CORNER_W'(k_ff[0] ? i1_ff[0] : i0_ff[0]);
   assign corner_oor = !(32'(corner) < STORE_DEPTH);
   assign ram_raddr  = corner[ADDR_W-1:0];
   assign pk         = 3'(k_ff - 1'b1);

   always_comb begin
      case (ch_ff)
         CH_RED:   cur_val = ram_rdata[0 +: VAL_W];
         CH_GREEN: cur_val = ram_rdata[VAL_W +: VAL_W];
         default:  cur_val = ram_rdata[2*VAL_W +: VAL_W];
      endcase
      if (rd_oor_ff) begin
         cur_val = '0;
      end
   end

   // shared blend unit: a + ((b - a) * f) >> 16, floor
   always_comb begin
      logic signed [VAL_W:0]        diff;
      logic signed [VAL_W+FRAC_W+1:0] prod;
      logic signed [VAL_W+2:0]      sum;
      case (state_ff)
         ST_BLY0: begin
            bl_a = cx_ff[0];
            bl_b = cx_ff[2];
            bl_f = fr_ff[1];
         end
         ST_BLY1: begin
            bl_a = cx_ff[1];
            bl_b = cx_ff[3];
            bl_f = fr_ff[1];
         end
         ST_OUT: begin
            bl_a = y0_ff;
            bl_b = y1_ff;
            bl_f = fr_ff[2];
         end
         default: begin
            bl_a = first_ff;
            bl_b = cur_val;
            bl_f = fr_ff[0];
         end
      endcase
      diff   = $signed({1'b0, bl_b}) - $signed({1'b0, bl_a});
      prod   = diff * $signed({1'b0, bl_f});
      sum    = $signed({3'b000, bl_a}) + (VAL_W+3)'(prod >>> FRAC_W);
      bl_res = sum[VAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      logic [POS_W+SIZE_W-1:0] s;
      logic [POS_W+SIZE_W-1:0] top;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         if (rsp_chan.ready && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc && req_chan.cmd) begin
                  ch_ff   <= ch_type'(req_chan.out_channel);
                  zero_ff <= zero_in;
                  state_ff <= zero_in ? ST_OUT : ST_MAP;
               end
            end
            ST_MAP: begin
               if (map_status.done) begin
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               for (int a = 0; a < LANES; a++) begin
                  s   = map_t[a] * n_lat;
                  top = (POS_W+SIZE_W)'(n_lat) << FRAC_W;
                  if (s > top) begin
                     s = top;
                  end
                  i0_ff[a] <= s[FRAC_W +: SIZE_W];
                  fr_ff[a] <= s[FRAC_W-1:0];
                  i1_ff[a] <= (s[FRAC_W +: SIZE_W] != n_lat) ?
                              s[FRAC_W +: SIZE_W] + 1'b1 : n_lat;
               end
               state_ff <= ST_ROW;
            end
            ST_ROW: begin
               for (int j = 0; j < 4; j++) begin
                  row_ff[j] <= (j[0] ? i1_ff[2] : i0_ff[2]) * size_ff +
                               ROW_W'(j[1] ? i1_ff[1] : i0_ff[1]);
               end
               state_ff <= ST_BASE;
            end
            ST_BASE: begin
               for (int j = 0; j < 4; j++) begin
                  base_ff[j] <= row_ff[j] * size_ff;
               end
               k_ff     <= '0;
               state_ff <= ST_READ;
            end
            ST_READ: begin
               rd_oor_ff <= corner_oor;
               k_ff      <= k_ff + 1'b1;
               if (k_ff != '0) begin
                  if (!pk[0]) begin
                     first_ff <= cur_val;
                  end else begin
                     cx_ff[pk[2:1]] <= bl_res;
                  end
               end
               if (k_ff == 4'd8) begin
                  state_ff <= ST_BLY0;
               end
            end
            ST_BLY0: begin
               y0_ff    <= bl_res;
               state_ff <= ST_BLY1;
            end
            ST_BLY1: begin
               y1_ff    <= bl_res;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= zero_ff ? '0 : bl_res;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.sampled_value = rsp_data_ff;

   a_ram_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_IDLE)
      else $error("lattice write outside idle");

   a_map_done_in_map: assert property (@(posedge clock) disable iff (reset)
      map_status.done |-> state_ff == ST_MAP)
      else $error("map result arrived outside map phase");

   a_read_to_blend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && k_ff == 4'd8) |=> state_ff == ST_BLY0)
      else $error("corner sweep did not end in blend");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside output state");

   a_no_map_busy_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !map_status.busy)
      else $error("divider busy while idle");

endmodule
